@@ rtl/dmpm_pkg.sv @@
// ----------------------------------------------------------------------------
// dmpm_pkg: shared definitions for the dual-mode PID motor mixer
// Field widths, error range, saturation limits, register indexes and the
// gain set type used by the control datapath.
// ----------------------------------------------------------------------------
package dmpm_pkg;

  localparam int HEAD_W    = 10;
  localparam int SPEED_W   = 9;
  localparam int WHEEL_W   = 10;
  localparam int CORR_W    = 9;
  localparam int GAIN_W    = 16;
  localparam int ERR_W     = 14;
  localparam int INTEG_W   = 32;
  localparam int CFG_IDX_W = 3;

  localparam int ERR_MAX = 8191;
  localparam int ERR_MIN = -8192;

  localparam int LIM_HEADING = 100;
  localparam int LIM_LINE    = 255;

  // Request type codes.
  localparam logic REQ_HEADING = 1'b0;
  localparam logic REQ_LINE    = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_KP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_KI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_KD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_KP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_KI = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_KD = 3'd5;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
  } gain_set_t;

endpackage

@@ rtl/dmpm_err_sel.sv @@
// ----------------------------------------------------------------------------
// dmpm_err_sel: control error selection
// Forms the heading error or the line sensor pair difference and saturates
// it to the signed error range.
// ----------------------------------------------------------------------------
module dmpm_err_sel import dmpm_pkg::*; #(
  parameter int SENSOR_BITS = 12
) (
  input  logic                          req_type_i,
  input  logic signed [HEAD_W-1:0]      target_heading_i,
  input  logic signed [HEAD_W-1:0]      measured_heading_i,
  input  logic signed [SPEED_W-1:0]     base_speed_i,
  input  logic        [SENSOR_BITS-1:0] front_left_level_i,
  input  logic        [SENSOR_BITS-1:0] front_right_level_i,
  input  logic        [SENSOR_BITS-1:0] rear_left_level_i,
  input  logic        [SENSOR_BITS-1:0] rear_right_level_i,
  output logic signed [ERR_W-1:0]       err_o
);

  localparam int DIFF_W = (SENSOR_BITS + 1 > ERR_W) ? SENSOR_BITS + 1 : ERR_W;
  localparam logic signed [DIFF_W-1:0] DIFF_MAX = DIFF_W'(ERR_MAX);
  localparam logic signed [DIFF_W-1:0] DIFF_MIN = DIFF_W'(ERR_MIN);

  logic        [SENSOR_BITS-1:0] left_lvl;
  logic        [SENSOR_BITS-1:0] right_lvl;
  logic signed [DIFF_W-1:0]      line_diff;
  logic signed [DIFF_W-1:0]      head_diff;
  logic signed [DIFF_W-1:0]      diff;

  // A speed of zero counts as not moving forward and uses the rear pair.
  always_comb begin
    if (base_speed_i > 0) begin
      left_lvl  = front_left_level_i;
      right_lvl = front_right_level_i;
    end else begin
      left_lvl  = rear_left_level_i;
      right_lvl = rear_right_level_i;
    end
  end

  assign line_diff = $signed(DIFF_W'(right_lvl)) - $signed(DIFF_W'(left_lvl));
  assign head_diff = DIFF_W'(target_heading_i) - DIFF_W'(measured_heading_i);
  assign diff      = (req_type_i == REQ_LINE) ? line_diff : head_diff;

  always_comb begin
    if (diff > DIFF_MAX) begin
      err_o = ERR_W'(DIFF_MAX);
    end else if (diff < DIFF_MIN) begin
      err_o = ERR_W'(DIFF_MIN);
    end else begin
      err_o = ERR_W'(diff);
    end
  end

endmodule

@@ rtl/dmpm_pid_calc.sv @@
// ----------------------------------------------------------------------------
// dmpm_pid_calc: PID step arithmetic
// Updates the saturating integral, sums the three terms, scales by the gain
// fraction with truncation toward zero and saturates to the mode limit.
// ----------------------------------------------------------------------------
module dmpm_pid_calc import dmpm_pkg::*; #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                      line_mode_i,
  input  gain_set_t                 gains_i,
  input  logic signed [ERR_W-1:0]   err_i,
  input  logic signed [ERR_W-1:0]   prev_err_i,
  input  logic signed [INTEG_W-1:0] integ_i,
  output logic signed [INTEG_W-1:0] integ_o,
  output logic signed [CORR_W-1:0]  corr_o
);

  localparam int PROD_W  = ERR_W + GAIN_W;
  localparam int DELTA_W = ERR_W + 1;
  localparam int PROD_D_W = DELTA_W + GAIN_W;
  localparam int ACC_W   = INTEG_W + 1;
  localparam int SUM_W   = INTEG_W + 4;
  localparam int SHIFT   = GAIN_FRAC_BITS + 1;
  localparam logic signed [SUM_W-1:0] BIAS = SUM_W'((64'd1 << SHIFT) - 64'd1);
  localparam logic signed [SUM_W-1:0] LIM_H = SUM_W'(LIM_HEADING);
  localparam logic signed [SUM_W-1:0] LIM_L = SUM_W'(LIM_LINE);

  logic signed [PROD_W-1:0]   prod_p;
  logic signed [PROD_W-1:0]   prod_i;
  logic signed [DELTA_W-1:0]  delta;
  logic signed [PROD_D_W-1:0] prod_d;
  logic signed [ACC_W-1:0]    acc;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    sum_adj;
  logic signed [SUM_W-1:0]    quot;
  logic signed [SUM_W-1:0]    lim;

  assign prod_p = PROD_W'(err_i) * PROD_W'(gains_i.kp);
  assign prod_i = PROD_W'(err_i) * PROD_W'(gains_i.ki);
  assign delta  = DELTA_W'(err_i) - DELTA_W'(prev_err_i);
  assign prod_d = PROD_D_W'(delta) * PROD_D_W'(gains_i.kd);

  // The integral saturates at the signed 32-bit limits.
  assign acc = ACC_W'(integ_i) + ACC_W'(prod_i);
  always_comb begin
    case (acc[ACC_W-1:ACC_W-2])
      2'b01:   integ_o = {1'b0, {(INTEG_W-1){1'b1}}};
      2'b10:   integ_o = {1'b1, {(INTEG_W-1){1'b0}}};
      default: integ_o = acc[INTEG_W-1:0];
    endcase
  end

  assign sum = (SUM_W'(prod_p) <<< 1) + SUM_W'(integ_o) + (SUM_W'(prod_d) <<< 1);

  // A negative sum is biased before the shift so the quotient truncates toward zero.
  assign sum_adj = sum[SUM_W-1] ? (sum + BIAS) : sum;
  assign quot    = sum_adj >>> SHIFT;
  assign lim     = line_mode_i ? LIM_L : LIM_H;

  always_comb begin
    if (quot > lim) begin
      corr_o = CORR_W'(lim);
    end else if (quot < -lim) begin
      corr_o = CORR_W'(-lim);
    end else begin
      corr_o = CORR_W'(quot);
    end
  end

endmodule

@@ rtl/dmpm_mixer.sv @@
// ----------------------------------------------------------------------------
// dmpm_mixer: four wheel mixing
// Spreads the correction over the four motors, as a pure turn in heading
// mode and around the base speed in line mode.
// ----------------------------------------------------------------------------
module dmpm_mixer import dmpm_pkg::*; (
  input  logic                      line_mode_i,
  input  logic signed [SPEED_W-1:0] base_speed_i,
  input  logic signed [CORR_W-1:0]  corr_i,
  output logic signed [WHEEL_W-1:0] wheel_one_o,
  output logic signed [WHEEL_W-1:0] wheel_two_o,
  output logic signed [WHEEL_W-1:0] wheel_three_o,
  output logic signed [WHEEL_W-1:0] wheel_four_o
);

  logic signed [WHEEL_W-1:0] spd;
  logic signed [WHEEL_W-1:0] cx;

  assign spd = WHEEL_W'(base_speed_i);
  assign cx  = WHEEL_W'(corr_i);

  always_comb begin
    if (line_mode_i) begin
      wheel_one_o   = spd - cx;
      wheel_two_o   = -spd - cx;
      wheel_three_o = spd + cx;
      wheel_four_o  = -spd + cx;
    end else begin
      wheel_one_o   = cx;
      wheel_two_o   = cx;
      wheel_three_o = -cx;
      wheel_four_o  = -cx;
    end
  end

endmodule

@@ rtl/dual_mode_pid_motor_mixer_core.sv @@
// A result passes the input register, loaded at the transfer, and then the
// result register; the PID step between the two is combinational.
// Throughput: one item per cycle while results are taken; integral and previous
// error update on each advance, so consecutive items see each other's updates.
// Reset clears the pipeline valids, the integral and the previous error,
// and loads the gain registers with their default values.
// ----------------------------------------------------------------------------
// dual_mode_pid_motor_mixer_core: PID controller with four wheel mixing
// Heading and line-following PID step with per-mode Q8.8 gains, shared
// integral and derivative state, and a registered four-wheel output.
// ----------------------------------------------------------------------------
module dual_mode_pid_motor_mixer_core import dmpm_pkg::*; #(
  parameter int SENSOR_BITS    = 12,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic        [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic        [GAIN_W-1:0]      cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic signed [HEAD_W-1:0]      target_heading_i,
  input  logic signed [HEAD_W-1:0]      measured_heading_i,
  input  logic signed [SPEED_W-1:0]     base_speed_i,
  input  logic        [SENSOR_BITS-1:0] front_left_level_i,
  input  logic        [SENSOR_BITS-1:0] front_right_level_i,
  input  logic        [SENSOR_BITS-1:0] rear_left_level_i,
  input  logic        [SENSOR_BITS-1:0] rear_right_level_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [WHEEL_W-1:0]     wheel_one_o,
  output logic signed [WHEEL_W-1:0]     wheel_two_o,
  output logic signed [WHEEL_W-1:0]     wheel_three_o,
  output logic signed [WHEEL_W-1:0]     wheel_four_o,
  output logic signed [CORR_W-1:0]      correction_o
);

  gain_set_t head_gains_q;
  gain_set_t line_gains_q;
  gain_set_t gains_sel;

  logic                          req_q;
  logic signed [HEAD_W-1:0]      tgt_q;
  logic signed [HEAD_W-1:0]      meas_q;
  logic signed [SPEED_W-1:0]     speed_q;
  logic        [SENSOR_BITS-1:0] fl_q;
  logic        [SENSOR_BITS-1:0] fr_q;
  logic        [SENSOR_BITS-1:0] rl_q;
  logic        [SENSOR_BITS-1:0] rr_q;
  logic                          stage_valid_q;

  logic signed [ERR_W-1:0]   prev_err_q;
  logic signed [INTEG_W-1:0] integ_q;
  logic signed [ERR_W-1:0]   err_d;
  logic signed [INTEG_W-1:0] integ_d;
  logic signed [CORR_W-1:0]  corr_d;

  logic signed [WHEEL_W-1:0] w1_d, w2_d, w3_d, w4_d;
  logic signed [WHEEL_W-1:0] w1_q, w2_q, w3_q, w4_q;
  logic signed [CORR_W-1:0]  corr_q;
  logic                      out_valid_q;

  logic in_xfer;
  logic advance;

  assign cfg_ready_o = 1'b1;

  // The stage moves on whenever the result register is free or being drained.
  assign advance    = stage_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !stage_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_gains_q.kp <= 16'sd512;
      head_gains_q.ki <= 16'sd0;
      head_gains_q.kd <= 16'sd0;
      line_gains_q.kp <= 16'sd20;
      line_gains_q.ki <= 16'sd0;
      line_gains_q.kd <= 16'sd256;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_HEAD_KP: head_gains_q.kp <= cfg_data_i;
        REG_HEAD_KI: head_gains_q.ki <= cfg_data_i;
        REG_HEAD_KD: head_gains_q.kd <= cfg_data_i;
        REG_LINE_KP: line_gains_q.kp <= cfg_data_i;
        REG_LINE_KI: line_gains_q.ki <= cfg_data_i;
        REG_LINE_KD: line_gains_q.kd <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (in_xfer) begin
      stage_valid_q <= 1'b1;
    end else if (advance) begin
      stage_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q   <= req_type_i;
      tgt_q   <= target_heading_i;
      meas_q  <= measured_heading_i;
      speed_q <= base_speed_i;
      fl_q    <= front_left_level_i;
      fr_q    <= front_right_level_i;
      rl_q    <= rear_left_level_i;
      rr_q    <= rear_right_level_i;
    end
  end

  assign gains_sel = (req_q == REQ_LINE) ? line_gains_q : head_gains_q;

  dmpm_err_sel #(
    .SENSOR_BITS (SENSOR_BITS)
  ) u_err_sel (
    .req_type_i          (req_q),
    .target_heading_i    (tgt_q),
    .measured_heading_i  (meas_q),
    .base_speed_i        (speed_q),
    .front_left_level_i  (fl_q),
    .front_right_level_i (fr_q),
    .rear_left_level_i   (rl_q),
    .rear_right_level_i  (rr_q),
    .err_o               (err_d)
  );

  dmpm_pid_calc #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_pid_calc (
    .line_mode_i (req_q),
    .gains_i     (gains_sel),
    .err_i       (err_d),
    .prev_err_i  (prev_err_q),
    .integ_i     (integ_q),
    .integ_o     (integ_d),
    .corr_o      (corr_d)
  );

  dmpm_mixer u_mixer (
    .line_mode_i   (req_q),
    .base_speed_i  (speed_q),
    .corr_i        (corr_d),
    .wheel_one_o   (w1_d),
    .wheel_two_o   (w2_d),
    .wheel_three_o (w3_d),
    .wheel_four_o  (w4_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
      integ_q    <= '0;
    end else if (advance) begin
      prev_err_q <= err_d;
      integ_q    <= integ_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      w1_q   <= w1_d;
      w2_q   <= w2_d;
      w3_q   <= w3_d;
      w4_q   <= w4_d;
      corr_q <= corr_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign wheel_one_o   = w1_q;
  assign wheel_two_o   = w2_q;
  assign wheel_three_o = w3_q;
  assign wheel_four_o  = w4_q;
  assign correction_o  = corr_q;

endmodule

@@ bench/tb_dual_mode_pid_motor_mixer_core.sv @@
// ----------------------------------------------------------------------------
// tb_dual_mode_pid_motor_mixer_core: self-checking bench for the PID mixer
// Drives heading and line steps through the input channel and writes gain
// sets through the configuration channel between phases. A behavioral model
// of the PID step predicts every wheel result, and a monitor compares them
// in order. Both channels idle at random, and one phase holds the result
// channel off long enough to fill the pipeline.
// ----------------------------------------------------------------------------
module tb_dual_mode_pid_motor_mixer_core;
  import dmpm_pkg::*;

  localparam int SENSOR_BITS    = 12;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_ITEMS    = 150;
  localparam int SENSOR_MAX     = (1 << SENSOR_BITS) - 1;

  localparam longint INT_HI   = 2147483647;
  localparam longint INT_LO   = -INT_HI - 1;
  localparam longint GAIN_DIV = longint'(1) << (GAIN_FRAC_BITS + 1);
  // Integral change of one full-scale line step at the largest positive integral gain.
  localparam longint INTEG_STEP_MAX = longint'(SENSOR_MAX) * 32767;

  typedef struct {
    logic                          req;
    logic signed [HEAD_W-1:0]      target;
    logic signed [HEAD_W-1:0]      measured;
    logic signed [SPEED_W-1:0]     speed;
    logic        [SENSOR_BITS-1:0] fl;
    logic        [SENSOR_BITS-1:0] fr;
    logic        [SENSOR_BITS-1:0] rl;
    logic        [SENSOR_BITS-1:0] rr;
  } pid_sample_t;

  typedef struct {
    logic signed [WHEEL_W-1:0] w1;
    logic signed [WHEEL_W-1:0] w2;
    logic signed [WHEEL_W-1:0] w3;
    logic signed [WHEEL_W-1:0] w4;
    logic signed [CORR_W-1:0]  corr;
  } wheel_set_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                          cfg_valid;
  logic                          cfg_ready_o;
  logic        [CFG_IDX_W-1:0]   cfg_index;
  logic        [GAIN_W-1:0]      cfg_data;
  logic                          in_valid;
  logic                          in_ready_o;
  logic                          req_type;
  logic signed [HEAD_W-1:0]      target_heading;
  logic signed [HEAD_W-1:0]      measured_heading;
  logic signed [SPEED_W-1:0]     base_speed;
  logic        [SENSOR_BITS-1:0] front_left_level;
  logic        [SENSOR_BITS-1:0] front_right_level;
  logic        [SENSOR_BITS-1:0] rear_left_level;
  logic        [SENSOR_BITS-1:0] rear_right_level;
  logic                          out_valid_o;
  logic                          out_ready;
  logic signed [WHEEL_W-1:0]     wheel_one_o;
  logic signed [WHEEL_W-1:0]     wheel_two_o;
  logic signed [WHEEL_W-1:0]     wheel_three_o;
  logic signed [WHEEL_W-1:0]     wheel_four_o;
  logic signed [CORR_W-1:0]      correction_o;

  // Model state and configuration.
  logic signed [GAIN_W-1:0] gain_q [6];
  int integ_q;
  int prev_err_q;

  wheel_set_t wheel_expect_q [$];

  int fail_count    = 0;
  int checked_count = 0;
  int heading_sent  = 0;
  int line_sent     = 0;
  int gain_writes   = 0;
  int hold_cycles   = 0;
  bit tx_idle_en    = 1'b1;
  bit rx_idle_en    = 1'b1;

  dual_mode_pid_motor_mixer_core #(
    .SENSOR_BITS   (SENSOR_BITS),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready_o),
    .req_type_i         (req_type),
    .target_heading_i   (target_heading),
    .measured_heading_i (measured_heading),
    .base_speed_i       (base_speed),
    .front_left_level_i (front_left_level),
    .front_right_level_i(front_right_level),
    .rear_left_level_i  (rear_left_level),
    .rear_right_level_i (rear_right_level),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready),
    .wheel_one_o        (wheel_one_o),
    .wheel_two_o        (wheel_two_o),
    .wheel_three_o      (wheel_three_o),
    .wheel_four_o       (wheel_four_o),
    .correction_o       (correction_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [GAIN_W-1:0] default_gain(input int idx);
    case (idx)
      REG_HEAD_KP: return 16'd512;
      REG_LINE_KP: return 16'd20;
      REG_LINE_KD: return 16'd256;
      default:     return '0;
    endcase
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // One PID step: updates the integral and previous error and returns the
  // wheel drive values.
  function automatic wheel_set_t pid_step(input pid_sample_t s);
    longint err, kp, ki, kd, acc, total, x, lim, spd;
    int gbase;
    wheel_set_t r;
    spd = longint'(s.speed);
    if (s.req == REQ_LINE) begin
      // A speed of zero counts as reverse and reads the rear pair.
      if (spd > 0) err = longint'(s.fr) - longint'(s.fl);
      else         err = longint'(s.rr) - longint'(s.rl);
      lim   = LIM_LINE;
      gbase = REG_LINE_KP;
    end else begin
      err   = longint'(s.target) - longint'(s.measured);
      lim   = LIM_HEADING;
      gbase = REG_HEAD_KP;
    end
    err = clamp(err, ERR_MIN, ERR_MAX);
    kp  = longint'(gain_q[gbase]);
    ki  = longint'(gain_q[gbase + 1]);
    kd  = longint'(gain_q[gbase + 2]);
    acc = longint'(integ_q) + err * ki;
    integ_q = int'(clamp(acc, INT_LO, INT_HI));
    total = 2 * kp * err + longint'(integ_q) + 2 * kd * (err - longint'(prev_err_q));
    // Signed division truncates toward zero.
    x = clamp(total / GAIN_DIV, -lim, lim);
    prev_err_q = int'(err);
    if (s.req == REQ_LINE) begin
      r.w1 = WHEEL_W'(spd - x);
      r.w2 = WHEEL_W'(-spd - x);
      r.w3 = WHEEL_W'(spd + x);
      r.w4 = WHEEL_W'(-spd + x);
    end else begin
      r.w1 = WHEEL_W'(x);
      r.w2 = WHEEL_W'(x);
      r.w3 = WHEEL_W'(-x);
      r.w4 = WHEEL_W'(-x);
    end
    r.corr = CORR_W'(x);
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic int near(input int base, input int spread, input int lo, input int hi);
    return int'(clamp(base + int'($urandom_range(2 * spread)) - spread, lo, hi));
  endfunction

  function automatic pid_sample_t heading_stim(input int tgt, input int meas);
    pid_sample_t s;
    s.req      = REQ_HEADING;
    s.target   = HEAD_W'(tgt);
    s.measured = HEAD_W'(meas);
    s.speed    = SPEED_W'($urandom());
    s.fl       = SENSOR_BITS'($urandom());
    s.fr       = SENSOR_BITS'($urandom());
    s.rl       = SENSOR_BITS'($urandom());
    s.rr       = SENSOR_BITS'($urandom());
    return s;
  endfunction

  function automatic pid_sample_t line_stim(input int spd, input int fl, input int fr,
                                            input int rl, input int rr);
    pid_sample_t s;
    s.req      = REQ_LINE;
    s.target   = HEAD_W'($urandom());
    s.measured = HEAD_W'($urandom());
    s.speed    = SPEED_W'(spd);
    s.fl       = SENSOR_BITS'(fl);
    s.fr       = SENSOR_BITS'(fr);
    s.rl       = SENSOR_BITS'(rl);
    s.rr       = SENSOR_BITS'(rr);
    return s;
  endfunction

  // Line step with the front pair at full scale in one direction.
  function automatic pid_sample_t full_push(input bit positive);
    if (positive) return line_stim(100, 0, SENSOR_MAX, 0, 0);
    return line_stim(100, SENSOR_MAX, 0, 0, 0);
  endfunction

  // Roughly half near-balanced errors so that the correction is not always pinned.
  function automatic pid_sample_t rand_stim();
    pid_sample_t s;
    int roll;
    roll = $urandom_range(99);
    s.req = 1'($urandom_range(1));
    if (roll < 10) begin
      s.target   = HEAD_W'($urandom());
      s.measured = HEAD_W'($urandom());
    end else begin
      s.target = HEAD_W'(int'($urandom_range(720)) - 360);
      if ($urandom_range(1)) s.measured = HEAD_W'(int'($urandom_range(720)) - 360);
      else                   s.measured = HEAD_W'(near(int'(s.target), 40, -360, 360));
    end
    roll = $urandom_range(99);
    if (roll < 10)      s.speed = '0;
    else if (roll < 20) s.speed = SPEED_W'($urandom());
    else                s.speed = SPEED_W'(int'($urandom_range(510)) - 255);
    s.fl = SENSOR_BITS'($urandom_range(SENSOR_MAX));
    s.rl = SENSOR_BITS'($urandom_range(SENSOR_MAX));
    if ($urandom_range(1)) s.fr = SENSOR_BITS'($urandom_range(SENSOR_MAX));
    else                   s.fr = SENSOR_BITS'(near(int'(s.fl), 100, 0, SENSOR_MAX));
    if ($urandom_range(1)) s.rr = SENSOR_BITS'($urandom_range(SENSOR_MAX));
    else                   s.rr = SENSOR_BITS'(near(int'(s.rl), 100, 0, SENSOR_MAX));
    return s;
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain(input int style, input int idx);
    bit is_int;
    is_int = (idx == REG_HEAD_KI) || (idx == REG_LINE_KI);
    case (style)
      0: return default_gain(idx);
      1: begin
        if (is_int) return GAIN_W'(int'($urandom_range(32)) - 16);
        return GAIN_W'(int'($urandom_range(1200)) - 600);
      end
      2: return GAIN_W'($urandom());
      default: begin
        case ($urandom_range(4))
          0:       return 16'h7fff;
          1:       return 16'h8000;
          2:       return 16'h0001;
          3:       return 16'hffff;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  task automatic send_stim(input pid_sample_t s);
    in_valid          <= 1'b1;
    req_type          <= s.req;
    target_heading    <= s.target;
    measured_heading  <= s.measured;
    base_speed        <= s.speed;
    front_left_level  <= s.fl;
    front_right_level <= s.fr;
    rear_left_level   <= s.rl;
    rear_right_level  <= s.rr;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    wheel_expect_q.push_back(pid_step(s));
    if (s.req == REQ_LINE) line_sent++;
    else                   heading_sent++;
  endtask

  task automatic tx_gap();
    int n;
    n = tx_idle_en ? pick_gap() : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_gapped(input pid_sample_t s);
    send_stim(s);
    tx_gap();
  endtask

  // Wait until every predicted result has been taken; the block is idle then.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (wheel_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    gain_q[idx] = value;
    gain_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic report_error(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] result %0d: %s", $realtime, checked_count, msg);
  endtask

  // Walk the shared integral back near zero with full-scale line steps,
  // then one trimmed step.
  task automatic recenter_integral();
    longint mag;
    longint k;
    drain();
    write_gain(REG_LINE_KI, 16'h7fff);
    while (longint'(integ_q) >= INTEG_STEP_MAX || longint'(integ_q) <= -INTEG_STEP_MAX)
      send_gapped(full_push(integ_q < 0));
    drain();
    mag = (integ_q < 0) ? -longint'(integ_q) : longint'(integ_q);
    k   = mag / SENSOR_MAX;
    if (k > 0) begin
      write_gain(REG_LINE_KI, GAIN_W'(k));
      send_stim(full_push(integ_q < 0));
      drain();
    end
  endtask

  task automatic test_reset_gains();
    send_gapped(heading_stim(0, 0));
    send_gapped(heading_stim(360, -360));
    send_gapped(heading_stim(-360, 360));
    send_gapped(heading_stim(10, 0));
    send_gapped(heading_stim(-37, 0));
    send_gapped(heading_stim(-512, 511));
    send_gapped(line_stim(255, 0, SENSOR_MAX, 0, 0));
    send_gapped(line_stim(1, SENSOR_MAX, 0, 0, 0));
    send_gapped(line_stim(0, 0, 0, 0, SENSOR_MAX));
    send_gapped(line_stim(-255, 0, 0, SENSOR_MAX, 0));
    send_gapped(line_stim(-256, SENSOR_MAX, SENSOR_MAX, SENSOR_MAX, SENSOR_MAX));
    send_gapped(line_stim(-1, 0, 0, 0, 0));
    drain();
  endtask

  task automatic test_gain_extremes();
    write_gain(REG_HEAD_KP, 16'h7fff);
    write_gain(REG_HEAD_KD, 16'h8000);
    write_gain(REG_LINE_KP, 16'h7fff);
    write_gain(REG_LINE_KD, 16'h8000);
    send_gapped(heading_stim(1, 0));
    send_gapped(heading_stim(-1, 0));
    send_gapped(line_stim(5, 0, 1, 0, 0));
    send_gapped(line_stim(-5, 0, 0, 1, 0));
    drain();
    write_gain(REG_HEAD_KP, 16'h8000);
    write_gain(REG_HEAD_KD, 16'h7fff);
    write_gain(REG_LINE_KP, 16'h8000);
    write_gain(REG_LINE_KD, 16'h7fff);
    send_gapped(heading_stim(200, -200));
    send_gapped(line_stim(50, SENSOR_MAX, 0, 0, 0));
    drain();
    // Tiny gains make the final division truncate on both signs.
    write_gain(REG_HEAD_KP, 16'h0001);
    write_gain(REG_HEAD_KD, 16'hffff);
    write_gain(REG_LINE_KP, 16'h0001);
    write_gain(REG_LINE_KD, 16'hffff);
    send_gapped(heading_stim(-300, 0));
    send_gapped(heading_stim(300, 0));
    send_gapped(line_stim(0, 0, 0, 300, 0));
    drain();
  endtask

  // Push the integral into both saturation limits, then bring it back.
  task automatic test_integral_saturation();
    write_gain(REG_LINE_KI, 16'h7fff);
    while (longint'(integ_q) != INT_HI) send_gapped(full_push(1'b1));
    send_gapped(full_push(1'b1));
    while (longint'(integ_q) != INT_LO) send_gapped(full_push(1'b0));
    send_gapped(full_push(1'b0));
    recenter_integral();
    write_gain(REG_LINE_KI, '0);
  endtask

  // The receiver holds off while the sender keeps offering items back to
  // back, so the input side has to stall.
  task automatic test_backpressure();
    tx_idle_en  = 1'b0;
    hold_cycles = 150;
    repeat (40) send_stim(rand_stim());
    drain();
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      if (integ_q > 100000 || integ_q < -100000) recenter_integral();
      for (int r = REG_HEAD_KP; r <= REG_LINE_KD; r++)
        write_gain(CFG_IDX_W'(r), pick_gain(ph % 4, r));
      tx_idle_en = (ph != 1) && ($urandom_range(3) != 0);
      rx_idle_en = (ph != 1) && ($urandom_range(3) != 0);
      repeat (PHASE_ITEMS) send_gapped(rand_stim());
    end
    drain();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin : hold_counter
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) hold_cycles--;
    end
  end

  initial begin : result_monitor
    int stall;
    wheel_set_t want;
    stall = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready) begin
        if (wheel_expect_q.size() == 0) begin
          report_error("result transfer with nothing expected");
        end else begin
          want = wheel_expect_q.pop_front();
          if (wheel_one_o !== want.w1)
            report_error($sformatf("wheel_one expected %0d, got %0d", want.w1, wheel_one_o));
          if (wheel_two_o !== want.w2)
            report_error($sformatf("wheel_two expected %0d, got %0d", want.w2, wheel_two_o));
          if (wheel_three_o !== want.w3)
            report_error($sformatf("wheel_three expected %0d, got %0d", want.w3,
                                   wheel_three_o));
          if (wheel_four_o !== want.w4)
            report_error($sformatf("wheel_four expected %0d, got %0d", want.w4,
                                   wheel_four_o));
          if (correction_o !== want.corr)
            report_error($sformatf("correction expected %0d, got %0d", want.corr,
                                   correction_o));
          checked_count++;
        end
      end
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
      end else if (!rx_idle_en) begin
        out_ready <= 1'b1;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        stall = pick_gap();
        out_ready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : main_seq
    rst_ni            <= 1'b0;
    cfg_valid         <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    in_valid          <= 1'b0;
    req_type          <= REQ_HEADING;
    target_heading    <= '0;
    measured_heading  <= '0;
    base_speed        <= '0;
    front_left_level  <= '0;
    front_right_level <= '0;
    rear_left_level   <= '0;
    rear_right_level  <= '0;
    for (int r = REG_HEAD_KP; r <= REG_LINE_KD; r++) gain_q[r] = default_gain(r);
    integ_q    = 0;
    prev_err_q = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_reset_gains();
    test_gain_extremes();
    test_integral_saturation();
    test_backpressure();
    test_random_phases();

    drain();
    repeat (8) @(posedge clk_i);
    if (wheel_expect_q.size() != 0)
      report_error($sformatf("%0d results never arrived", wheel_expect_q.size()));
    $display("Covered %0d heading and %0d line steps, %0d results checked.",
             heading_sent, line_sent, checked_count);
    $display("Gains: %0d register writes over %0d random phases, with integral saturation.",
             gain_writes, NUM_PHASES);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d errors in total", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
